FILE: sv/lowest_beam_mosaic_merge_macros.svh
// assertion macros shared by the mosaic merge modules
`ifndef LOWEST_BEAM_MOSAIC_MERGE_MACROS_SVH
`define LOWEST_BEAM_MOSAIC_MERGE_MACROS_SVH

// same-cycle implication, checked outside reset
`define LBMM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define LBMM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/lbmm_pkg.sv
// shared types and constants of the lowest-beam mosaic merge
package lbmm_pkg;

  localparam int InDataW  = 72;
  localparam int OutDataW = 48;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;
  localparam int BinSpan  = 256;
  localparam int QueueDepth = 2;

  localparam logic [CfgIdxW-1:0] RegRowOffset  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegColOffset  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegGridRows   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegGridCols   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSiteElev   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegRadarIndex = 3'd5;

  typedef enum logic [1:0] {
    KIND_ZERO,
    KIND_OUTSIDE,
    KIND_READ,
    KIND_MERGE
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [15:0]        rain;
    logic signed [17:0] height;
    logic               flag;
  } job_t;

  typedef struct packed {
    logic signed [17:0] height;
    logic [15:0]        rain;
    logic [7:0]         source;
  } cell_t;

  localparam cell_t CellReset = '{height: 18'sd131071, rain: 16'd0, source: 8'd255};

  typedef struct packed {
    logic signed [15:0] row_offset;
    logic signed [15:0] col_offset;
    logic [8:0]         grid_rows;
    logic [8:0]         grid_cols;
    logic signed [13:0] site_elev;
  } cfg_t;

endpackage

FILE: sv/lbmm_front.sv
// front end: unpacks an input word, places the bin on the grid and classifies it
module lbmm_front #(
  parameter int GRID_SIDE = 256,
  parameter int CW        = 8
) (
  input  logic                        s_valid_i,
  input  logic [lbmm_pkg::InDataW-1:0] s_data_i,
  input  logic                        s_user_i,
  input  lbmm_pkg::cfg_t              cfg_i,
  input  logic                        space_i,
  output logic                        s_ready_o,
  output logic                        push_o,
  output lbmm_pkg::job_t              job_o,
  output logic [2*CW-1:0]             addr_o
);

  localparam int SideW = $clog2(GRID_SIDE + 1);

  logic [7:0]         bin_row, bin_col, read_row, read_col;
  logic [15:0]        rain, beam;
  logic               flag;
  logic signed [16:0] mr, mc;
  logic [SideW-1:0]   lim_r, lim_c;
  logic               row_out, col_out, beyond_span, read_out;

  assign bin_row  = s_data_i[7:0];
  assign bin_col  = s_data_i[15:8];
  assign rain     = s_data_i[31:16];
  assign beam     = s_data_i[47:32];
  assign flag     = s_data_i[48];
  assign read_row = s_data_i[56:49];
  assign read_col = s_data_i[64:57];

  assign s_ready_o = space_i;
  assign push_o    = s_valid_i && space_i;

  assign mr = $signed({cfg_i.row_offset[15], cfg_i.row_offset}) + $signed({9'd0, bin_row});
  assign mc = $signed({cfg_i.col_offset[15], cfg_i.col_offset}) + $signed({9'd0, bin_col});

  // grid size limits taken from the registers saturate at the grid side
  assign lim_r = (32'(cfg_i.grid_rows) > GRID_SIDE) ? SideW'(GRID_SIDE)
                                                     : SideW'(cfg_i.grid_rows);
  assign lim_c = (32'(cfg_i.grid_cols) > GRID_SIDE) ? SideW'(GRID_SIDE)
                                                     : SideW'(cfg_i.grid_cols);

  assign row_out = mr[16] || (mr[15:0] >= 16'(lim_r));
  assign col_out = mc[16] || (mc[15:0] >= 16'(lim_c));
  assign beyond_span = (32'(bin_row) >= lbmm_pkg::BinSpan) ||
                       (32'(bin_col) >= lbmm_pkg::BinSpan);
  assign read_out = (32'(read_row) >= GRID_SIDE) || (32'(read_col) >= GRID_SIDE);

  always_comb begin
    job_o.rain   = rain;
    job_o.flag   = flag;
    job_o.height = $signed({2'b00, beam}) +
                   $signed({{4{cfg_i.site_elev[13]}}, cfg_i.site_elev});
    addr_o       = {mr[CW-1:0], mc[CW-1:0]};
    if (s_user_i) begin
      addr_o     = {CW'(read_row), CW'(read_col)};
      job_o.kind = read_out ? lbmm_pkg::KIND_OUTSIDE : lbmm_pkg::KIND_READ;
    end else if (rain[15] || beyond_span) begin
      job_o.kind = lbmm_pkg::KIND_ZERO;
    end else if (row_out || col_out) begin
      job_o.kind = lbmm_pkg::KIND_OUTSIDE;
    end else begin
      job_o.kind = lbmm_pkg::KIND_MERGE;
    end
  end

endmodule

FILE: sv/lbmm_queue.sv
// short queue of classified words between front and back
`include "lowest_beam_mosaic_merge_macros.svh"

module lbmm_queue #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output logic [W-1:0] data_o
);

  localparam int PW = $clog2(lbmm_pkg::QueueDepth);
  localparam int NW = $clog2(lbmm_pkg::QueueDepth + 1);

  logic [W-1:0]  slot_q [lbmm_pkg::QueueDepth];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [NW-1:0] cnt_q, cnt_d;

  assign full_o  = (32'(cnt_q) == lbmm_pkg::QueueDepth);
  assign valid_o = (cnt_q != '0);
  assign data_o  = slot_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (32'(wr_q) == lbmm_pkg::QueueDepth - 1) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (32'(rd_q) == lbmm_pkg::QueueDepth - 1) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= data_i;
    end
  end

  `LBMM_ASSERT_NOW(a_no_push_full, full_o && !pop_i, !push_i, "push into full queue")
  `LBMM_ASSERT_NOW(a_no_pop_empty, pop_i, valid_o, "pop from empty queue")

endmodule

FILE: sv/lbmm_back.sv
// back end: clears the cell store, then reads, compares and writes cells
`include "lowest_beam_mosaic_merge_macros.svh"

module lbmm_back #(
  parameter int AW = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  lbmm_pkg::job_t       q_job_i,
  input  logic [AW-1:0]        q_addr_i,
  output logic                 q_pop_o,
  input  logic [7:0]           radar_index_i,
  output logic                 clearing_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output lbmm_pkg::cell_t      out_cell_o,
  output logic                 out_updated_o,
  output logic                 out_outside_o
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_RMW   = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [AW-1:0]   clr_q, clr_d;
  lbmm_pkg::cell_t mem [2**AW];
  lbmm_pkg::cell_t rd_q;
  lbmm_pkg::job_t  job_q;
  logic [AW-1:0]   addr_q;
  logic            out_free, mem_re, mem_we, upd, load;
  logic [AW-1:0]   mem_waddr;
  lbmm_pkg::cell_t mem_wdata, new_cell;
  logic            out_valid_q;
  lbmm_pkg::cell_t out_cell_q, out_cell_d;
  logic            upd_q, upd_d, outside_q, outside_d;

  assign out_free   = !out_valid_q || out_ready_i;
  assign clearing_o = (state_q == ST_CLEAR);

  assign new_cell.height = job_q.height;
  assign new_cell.rain   = job_q.rain;
  assign new_cell.source = radar_index_i;
  assign upd = (job_q.kind == lbmm_pkg::KIND_MERGE) && job_q.flag &&
               (job_q.height < rd_q.height);

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    q_pop_o    = 1'b0;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = addr_q;
    mem_wdata  = new_cell;
    load       = 1'b0;
    out_cell_d = '0;
    upd_d      = 1'b0;
    outside_d  = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = lbmm_pkg::CellReset;
        clr_d     = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid_i && out_free) begin
          q_pop_o = 1'b1;
          if (q_job_i.kind == lbmm_pkg::KIND_READ || q_job_i.kind == lbmm_pkg::KIND_MERGE) begin
            mem_re  = 1'b1;
            state_d = ST_RMW;
          end else begin
            load      = 1'b1;
            outside_d = (q_job_i.kind == lbmm_pkg::KIND_OUTSIDE);
          end
        end
      end
      ST_RMW: begin
        if (out_free) begin
          load       = 1'b1;
          mem_we     = upd;
          upd_d      = upd;
          out_cell_d = upd ? new_cell : rd_q;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      job_q  <= q_job_i;
      addr_q <= q_addr_i;
    end
    if (load) begin
      out_cell_q <= out_cell_d;
      upd_q      <= upd_d;
      outside_q  <= outside_d;
    end
  end

  // cell store, single port use: read and write never share a cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[q_addr_i];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_cell_o    = out_cell_q;
  assign out_updated_o = upd_q;
  assign out_outside_o = outside_q;

  `LBMM_ASSERT_NOW(a_no_pop_clear, state_q == ST_CLEAR, !q_pop_o, "queue popped during clear")
  `LBMM_ASSERT_NOW(a_write_merge_only, (state_q == ST_RMW) && mem_we,
                   job_q.kind == lbmm_pkg::KIND_MERGE, "cell written by a non-merge word")
  `LBMM_ASSERT_NEXT(a_rmw_waits, (state_q == ST_RMW) && !out_free,
                    state_q == ST_RMW, "compare step left while output blocked")

endmodule

FILE: sv/lowest_beam_mosaic_merge.sv
// Lowest-beam mosaic merge: radar bins are merged into a grid of cells, keeping
// per cell the flagged bin of lowest beam height; read words return one cell.
// Input stream s_axis: tuser selects merge (0) or read (1), tdata carries the
// bin fields and the read address. Output stream m_axis: one word per input
// word, in order, with the cell contents and the updated / outside flags.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i; write it
// only while no word is in flight.
// A word that touches a cell is read from the cell store, then compared and
// written through one port, and the back end takes the next word only after
// that; a word that touches no cell goes straight to the output register. A
// two-entry queue decouples the classifying front end.
// Reset: the cell store is cleared by a pass over all 2**(2*clog2(GRID_SIDE))
// cells (65536 at the default), during which s_axis_tready stays low;
// configuration writes are taken throughout. When m_axis_tready is low the
// output register holds its word, the back end stops and the queue fills, then
// s_axis_tready drops.
`include "lowest_beam_mosaic_merge_macros.svh"

module lowest_beam_mosaic_merge #(
  parameter int GRID_SIDE = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // bin_row, bin_col, rain_value, beam_height, misc_flag, read_row, read_col
  input  logic [lbmm_pkg::InDataW-1:0]        s_axis_tdata,
  // req_type
  input  logic [0:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // cell_rain, cell_height, cell_source, updated, outside_grid
  output logic [lbmm_pkg::OutDataW-1:0]       m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [lbmm_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [lbmm_pkg::CfgDataW-1:0]       cfg_data_i
);

  localparam int CW = $clog2(GRID_SIDE);
  localparam int AW = 2 * CW;
  localparam int QW = $bits(lbmm_pkg::job_t) + AW;

  lbmm_pkg::cfg_t  cfg_q;
  logic [7:0]      radar_index_q;
  logic            clearing, q_full, space, push, q_valid, q_pop;
  lbmm_pkg::job_t  f_job, q_job;
  logic [AW-1:0]   f_addr, q_addr;
  logic [QW-1:0]   q_out;
  lbmm_pkg::cell_t out_cell;
  logic            out_upd, out_outside;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_offset <= '0;
      cfg_q.col_offset <= '0;
      cfg_q.grid_rows  <= 9'd256;
      cfg_q.grid_cols  <= 9'd256;
      cfg_q.site_elev  <= '0;
      radar_index_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lbmm_pkg::RegRowOffset:  cfg_q.row_offset <= cfg_data_i;
        lbmm_pkg::RegColOffset:  cfg_q.col_offset <= cfg_data_i;
        lbmm_pkg::RegGridRows:   cfg_q.grid_rows  <= cfg_data_i[8:0];
        lbmm_pkg::RegGridCols:   cfg_q.grid_cols  <= cfg_data_i[8:0];
        lbmm_pkg::RegSiteElev:   cfg_q.site_elev  <= cfg_data_i[13:0];
        lbmm_pkg::RegRadarIndex: radar_index_q    <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  assign space = !q_full && !clearing;

  lbmm_front #(
    .GRID_SIDE(GRID_SIDE),
    .CW       (CW)
  ) u_front (
    .s_valid_i(s_axis_tvalid),
    .s_data_i (s_axis_tdata),
    .s_user_i (s_axis_tuser[0]),
    .cfg_i    (cfg_q),
    .space_i  (space),
    .s_ready_o(s_axis_tready),
    .push_o   (push),
    .job_o    (f_job),
    .addr_o   (f_addr)
  );

  lbmm_queue #(
    .W(QW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i ({f_job, f_addr}),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (q_out)
  );

  assign q_job  = q_out[QW-1:AW];
  assign q_addr = q_out[AW-1:0];

  lbmm_back #(
    .AW(AW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_job_i      (q_job),
    .q_addr_i     (q_addr),
    .q_pop_o      (q_pop),
    .radar_index_i(radar_index_q),
    .clearing_o   (clearing),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_cell_o   (out_cell),
    .out_updated_o(out_upd),
    .out_outside_o(out_outside)
  );

  assign m_axis_tdata = {4'b0000, out_outside, out_upd, out_cell.source,
                         out_cell.height, out_cell.rain};

  `LBMM_ASSERT_NOW(a_no_accept_clear, clearing, !s_axis_tready, "word accepted during clear")

endmodule

FILE: sim/lowest_beam_mosaic_merge_test.sv
// self-checking testbench of the lowest-beam mosaic merge: directed and random words
module lowest_beam_mosaic_merge_test;

  localparam int GridSide = 256;
  localparam logic REQ_MERGE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  typedef struct packed {
    logic               req;
    logic [7:0]         bin_row;
    logic [7:0]         bin_col;
    logic signed [15:0] rain;
    logic [15:0]        beam;
    logic               flag;
    logic [7:0]         read_row;
    logic [7:0]         read_col;
  } bin_word_t;

  typedef struct packed {
    logic signed [15:0] rain;
    logic signed [17:0] height;
    logic [7:0]         source;
    logic               updated;
    logic               outside;
  } cell_report_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [lbmm_pkg::InDataW-1:0]  s_axis_tdata;
  logic [0:0]                    s_axis_tuser;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [lbmm_pkg::OutDataW-1:0] m_axis_tdata;
  logic                          cfg_we_i;
  logic [lbmm_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [lbmm_pkg::CfgDataW-1:0] cfg_data_i;

  // shadow of the mosaic and of the registers
  logic signed [17:0] height_mem [GridSide*GridSide];
  logic [15:0]        rain_mem   [GridSide*GridSide];
  logic [7:0]         source_mem [GridSide*GridSide];
  logic signed [15:0] row_off_q;
  logic signed [15:0] col_off_q;
  logic [8:0]         rows_q;
  logic [8:0]         cols_q;
  logic signed [13:0] elev_q;
  logic [7:0]         radar_q;

  cell_report_t expected_cells [$];

  bit idle_on;
  int rx_hold_left;
  int mismatches;
  int n_words, n_reads, n_updates, n_outside, n_missing, n_settings;

  lowest_beam_mosaic_merge #(
    .GRID_SIDE(GridSide)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // works out the cell report of one word and applies the merge to the shadow
  function automatic cell_report_t lowest_beam_merge(bin_word_t w);
    cell_report_t r;
    int mr, mc, lim_r, lim_c, h;
    logic [15:0] a;
    r = '0;
    if (w.req == REQ_READ) begin
      a = {w.read_row, w.read_col};
      r.rain   = rain_mem[a];
      r.height = height_mem[a];
      r.source = source_mem[a];
      return r;
    end
    if (w.rain < 0) return r;
    lim_r = (rows_q > GridSide) ? GridSide : int'(rows_q);
    lim_c = (cols_q > GridSide) ? GridSide : int'(cols_q);
    mr = int'(row_off_q) + int'(w.bin_row);
    mc = int'(col_off_q) + int'(w.bin_col);
    if (mr < 0 || mc < 0 || mr >= lim_r || mc >= lim_c) begin
      r.outside = 1'b1;
      return r;
    end
    a = {mr[7:0], mc[7:0]};
    h = int'(w.beam) + int'(elev_q);
    if (w.flag && h < int'(height_mem[a])) begin
      height_mem[a] = 18'(h);
      rain_mem[a]   = w.rain;
      source_mem[a] = radar_q;
      r.updated     = 1'b1;
    end
    r.rain   = rain_mem[a];
    r.height = height_mem[a];
    r.source = source_mem[a];
    return r;
  endfunction

  function automatic bin_word_t merge_word(int br, int bc, int rain, int beam, bit flag);
    bin_word_t w;
    w.req      = REQ_MERGE;
    w.bin_row  = 8'(br);
    w.bin_col  = 8'(bc);
    w.rain     = 16'(rain);
    w.beam     = 16'(beam);
    w.flag     = flag;
    w.read_row = 8'($urandom);
    w.read_col = 8'($urandom);
    return w;
  endfunction

  function automatic bin_word_t read_word(int rr, int rc);
    bin_word_t w;
    w          = merge_word($urandom, $urandom, $urandom, $urandom, 1'($urandom));
    w.req      = REQ_READ;
    w.read_row = 8'(rr);
    w.read_col = 8'(rc);
    return w;
  endfunction

  // bin coordinate that mostly lands in the hot window of the mosaic
  function automatic int pick_bin(int hot, int off);
    int b;
    b = hot + int'($urandom_range(0, 7)) - off;
    if (b < 0 || b > 255 || $urandom_range(0, 9) == 0) b = int'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic bin_word_t random_word(int hot_r, int hot_c);
    bin_word_t w;
    int rain, beam;
    if ($urandom_range(0, 99) < 25) begin
      if ($urandom_range(0, 4) != 0) begin
        w = read_word(hot_r + int'($urandom_range(0, 7)), hot_c + int'($urandom_range(0, 7)));
      end else begin
        w = read_word($urandom, $urandom);
      end
      return w;
    end
    if ($urandom_range(0, 99) < 8) rain = int'($urandom_range(32768, 65535));
    else rain = int'($urandom_range(0, 32767));
    if ($urandom_range(0, 1) == 0) beam = int'($urandom_range(0, 65535));
    else beam = int'($urandom_range(0, 400));
    w = merge_word(pick_bin(hot_r, int'(row_off_q)), pick_bin(hot_c, int'(col_off_q)),
                   rain, beam, $urandom_range(0, 99) < 85);
    return w;
  endfunction

  task automatic send_word(bin_word_t w);
    cell_report_t r;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= w.req;
    s_axis_tdata  <= {7'd0, w.read_col, w.read_row, w.flag, w.beam, w.rain,
                      w.bin_col, w.bin_row};
    do @(posedge clk_i); while (!s_axis_tready);
    r = lowest_beam_merge(w);
    expected_cells.push_back(r);
    n_words++;
    if (w.req == REQ_READ) n_reads++;
    else if (w.rain < 0) n_missing++;
    if (r.updated) n_updates++;
    if (r.outside) n_outside++;
    // each cycle idles with the same odds
    while (idle_on && $urandom_range(0, 99) < 31) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
  endtask

  // sender stops and waits until every expected word has come back
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [lbmm_pkg::CfgIdxW-1:0] idx, int value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= 16'(value);
    case (idx)
      lbmm_pkg::RegRowOffset:  row_off_q = 16'(value);
      lbmm_pkg::RegColOffset:  col_off_q = 16'(value);
      lbmm_pkg::RegGridRows:   rows_q    = 9'(value);
      lbmm_pkg::RegGridCols:   cols_q    = 9'(value);
      lbmm_pkg::RegSiteElev:   elev_q    = 14'(value);
      lbmm_pkg::RegRadarIndex: radar_q   = 8'(value);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic program_site(int ro, int co, int gr, int gc, int el, int ix);
    wait_drained();
    write_reg(lbmm_pkg::RegRowOffset, ro);
    write_reg(lbmm_pkg::RegColOffset, co);
    write_reg(lbmm_pkg::RegGridRows, gr);
    write_reg(lbmm_pkg::RegGridCols, gc);
    write_reg(lbmm_pkg::RegSiteElev, el);
    write_reg(lbmm_pkg::RegRadarIndex, ix);
    n_settings++;
  endtask

  function automatic int hot_base(int lim, int off);
    int lo, hi;
    if (lim > GridSide) lim = GridSide;
    lo = (off > 0) ? off : 0;
    hi = ((lim < off + 256) ? lim : off + 256) - 8;
    return (hi > lo) ? lo + int'($urandom_range(0, hi - lo)) : lo;
  endfunction

  task automatic run_phase(int n, int ro, int co, int gr, int gc, int el, int ix);
    int hot_r, hot_c;
    program_site(ro, co, gr, gc, el, ix);
    hot_r = hot_base(gr, ro);
    hot_c = hot_base(gc, co);
    repeat (n) send_word(random_word(hot_r, hot_c));
  endtask

  // corners, untouched cells, missing rain, blocked bins and equal heights
  task automatic test_cell_basics();
    program_site(0, 0, 256, 256, 0, 7);
    send_word(read_word(0, 0));
    send_word(read_word(255, 255));
    send_word(merge_word(0, 0, 32767, 65535, 1'b1));
    send_word(merge_word(0, 0, 5, 0, 1'b0));
    send_word(merge_word(0, 0, 0, 65535, 1'b1));
    send_word(merge_word(0, 0, 100, 0, 1'b1));
    send_word(merge_word(3, 4, -32768, 0, 1'b1));
    send_word(merge_word(3, 4, -1, 0, 1'b1));
    send_word(merge_word(255, 255, 1234, 500, 1'b1));
    send_word(read_word(255, 255));
    send_word(read_word(0, 0));
  endtask

  // offsets, grid sizes, elevation and radar index at their limits
  task automatic test_register_limits();
    program_site(32767, -32768, 256, 256, 0, 0);
    send_word(merge_word(0, 255, 10, 10, 1'b1));
    program_site(-32768, 32767, 256, 256, 0, 0);
    send_word(merge_word(255, 0, 10, 10, 1'b1));
    program_site(-1, 0, 10, 0, 0, 0);
    send_word(merge_word(0, 0, 10, 10, 1'b1));
    program_site(-1, 0, 10, 511, 0, 0);
    send_word(merge_word(1, 200, 10, 10, 1'b1));
    send_word(merge_word(10, 5, 10, 10, 1'b1));
    send_word(merge_word(11, 5, 10, 10, 1'b1));
    program_site(0, 0, 257, 10, -512, 255);
    send_word(merge_word(255, 9, 77, 0, 1'b1));
    send_word(merge_word(255, 10, 77, 0, 1'b1));
    program_site(0, 0, 256, 256, 8191, 254);
    send_word(merge_word(20, 20, 300, 65535, 1'b1));
    send_word(merge_word(20, 20, 301, 65534, 1'b1));
    send_word(read_word(255, 9));
  endtask

  task automatic test_random_mix();
    run_phase(190, 0, 0, 256, 256, 0, 3);
    run_phase(190, 12, -7, 100, 200, -512, 17);
    idle_on = 1'b0;
    run_phase(190, -100, 50, 511, 300, 8191, 254);
    idle_on = 1'b1;
    run_phase(190, 200, 180, 240, 256, int'($urandom_range(0, 8703)) - 512, 255);
    run_phase(190, int'($urandom_range(0, 80)) - 40, int'($urandom_range(0, 80)) - 40,
              int'($urandom_range(0, 300)), int'($urandom_range(0, 300)),
              int'($urandom_range(0, 8703)) - 512, int'($urandom_range(0, 254)));
  endtask

  // output held off for a long time while words keep coming
  task automatic test_output_stall();
    program_site(0, 0, 256, 256, 100, 42);
    idle_on = 1'b0;
    rx_hold_left = 400;
    repeat (40) send_word(random_word(64, 64));
    idle_on = 1'b1;
  endtask

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_left > 0) begin
        m_axis_tready <= 1'b0;
        rx_hold_left--;
      end else if (idle_on) begin
        m_axis_tready <= ($urandom_range(0, 99) >= 31);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic note_mismatch(string what, longint want, longint got);
    mismatches++;
    if (mismatches <= 10) $display("mismatch in %s: expected %0d, got %0d", what, want, got);
  endtask

  always @(posedge clk_i) begin : check_cells
    cell_report_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.rain    = m_axis_tdata[15:0];
      got.height  = m_axis_tdata[33:16];
      got.source  = m_axis_tdata[41:34];
      got.updated = m_axis_tdata[42];
      got.outside = m_axis_tdata[43];
      if (expected_cells.size() == 0) begin
        note_mismatch("word with nothing pending, tdata", 0, longint'(m_axis_tdata));
      end else begin
        want = expected_cells.pop_front();
        if (got.rain !== want.rain) note_mismatch("cell_rain", want.rain, got.rain);
        if (got.height !== want.height) note_mismatch("cell_height", want.height, got.height);
        if (got.source !== want.source) note_mismatch("cell_source", want.source, got.source);
        if (got.updated !== want.updated) note_mismatch("updated", want.updated, got.updated);
        if (got.outside !== want.outside) note_mismatch("outside_grid", want.outside, got.outside);
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    idle_on       = 1'b1;
    rx_hold_left  = 0;
    row_off_q     = '0;
    col_off_q     = '0;
    rows_q        = 9'd256;
    cols_q        = 9'd256;
    elev_q        = '0;
    radar_q       = '0;
    for (int k = 0; k < GridSide * GridSide; k++) begin
      height_mem[k] = lbmm_pkg::CellReset.height;
      rain_mem[k]   = lbmm_pkg::CellReset.rain;
      source_mem[k] = lbmm_pkg::CellReset.source;
    end
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_cell_basics();
    test_register_limits();
    test_output_stall();
    test_random_mix();
    wait_drained();

    if (expected_cells.size() != 0) begin
      $display("%0d words never came back", expected_cells.size());
      mismatches += expected_cells.size();
    end
    $display("sent %0d words under %0d register settings: %0d reads, %0d cell updates,",
             n_words, n_settings, n_reads, n_updates);
    $display("%0d bins off the grid, %0d with missing rain; %0d mismatches",
             n_outside, n_missing, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/lbmm_pkg.sv
sv/lbmm_front.sv
sv/lbmm_queue.sv
sv/lbmm_back.sv
sv/lowest_beam_mosaic_merge.sv
sim/lowest_beam_mosaic_merge_test.sv
